### src/json_string_unescape_utf8_unit_macros.svh
// ----------------------------------------------------------------------------
// JSON string unescape unit - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jsu assertion failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jsu assertion failed");

`endif

### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape unit - package
// Result kind codes and the per-byte result bundle type.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam logic [2:0] K_DATA    = 3'd0;
	localparam logic [2:0] K_END     = 3'd1;
	localparam logic [2:0] K_CTRL    = 3'd2;
	localparam logic [2:0] K_ESC     = 3'd3;
	localparam logic [2:0] K_HEX     = 3'd4;
	localparam logic [2:0] K_SURR    = 3'd5;
	localparam logic [2:0] K_UNTERM  = 3'd6;
	localparam logic [2:0] K_NOQUOTE = 3'd7;

	localparam int MAX_RES = 5;

	// all results caused by one input byte, entry 0 goes out first
	typedef struct packed {
		logic [2:0]                 cnt;
		logic [MAX_RES-1:0][7:0]    byt;
		logic [MAX_RES-1:0][2:0]    knd;
	} bundle_t;

endpackage

### src/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON string unescape unit - byte decoder
// Parser state registers and the single-pass logic that turns one byte
// into a bundle of up to five results.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_s1,
	input  logic             last_s1,
	output jsu_pkg::bundle_t bnd
);
	import jsu_pkg::*;

	localparam logic [3:0] PH_WAIT = 4'd0;
	localparam logic [3:0] PH_BODY = 4'd1;
	localparam logic [3:0] PH_ESC  = 4'd2;
	localparam logic [3:0] PH_HEX1 = 4'd3;
	localparam logic [3:0] PH_BSL  = 4'd4;
	localparam logic [3:0] PH_UCH  = 4'd5;
	localparam logic [3:0] PH_HEX2 = 4'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic utf8_t enc(input logic [20:0] cp);
		utf8_t r;
		r.b = '0;
		if (cp <= 21'h7F) begin
			r.cnt  = 3'd1;
			r.b[0] = {1'b0, cp[6:0]};
		end else if (cp <= 21'h7FF) begin
			r.cnt  = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.cnt  = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.cnt  = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

	logic [3:0]  phase_q, ph_n;
	logic [1:0]  dcnt_q, dc_n;
	logic [15:0] hval_q, hv_n;
	logic [9:0]  hsur_q, hs_n;

	logic [4:0]      hx;
	logic [15:0]     hv_new;
	logic [20:0]     cp;
	utf8_t           u8;
	logic            ws;
	logic            is_hi, is_lo;
	logic [2:0]      mcnt;
	logic [3:0][7:0] mb;
	logic [3:0][2:0] mk;

	assign hx     = hex_digit(data_s1);
	assign hv_new = {hval_q[11:0], hx[3:0]};
	assign is_hi  = (hv_new[15:10] == 6'b110110);
	assign is_lo  = (hv_new[15:10] == 6'b110111);
	// surrogate pair: 0x10000 + (high bits << 10) + low bits
	assign cp     = (phase_q == PH_HEX2) ? 21'h10000 + {1'b0, hsur_q, hv_new[9:0]}
	                                     : {5'b0, hv_new};
	assign u8     = enc(cp);
	assign ws     = (data_s1 == CH_SP) || (data_s1 == CH_TAB) ||
	                (data_s1 == CH_CR) || (data_s1 == CH_LF);

	always_comb begin
		ph_n = phase_q;
		dc_n = dcnt_q;
		hv_n = hval_q;
		hs_n = hsur_q;
		mcnt = 3'd0;
		mb   = '0;
		mk   = '0;
		case (phase_q)
			PH_BODY: begin
				if (data_s1 == CH_QUOTE) begin
					mcnt = 3'd1; mk[0] = K_END; ph_n = PH_WAIT;
				end else if (data_s1 < CH_SP) begin
					mcnt = 3'd1; mk[0] = K_CTRL; ph_n = PH_WAIT;
				end else if (data_s1 == CH_BSL) begin
					ph_n = PH_ESC;
				end else begin
					mcnt = 3'd1; mb[0] = data_s1;
				end
			end
			PH_ESC: begin
				ph_n = PH_BODY;
				mcnt = 3'd1;
				case (data_s1)
					CH_QUOTE: mb[0] = CH_QUOTE;
					CH_BSL:   mb[0] = CH_BSL;
					CH_SLASH: mb[0] = CH_SLASH;
					CH_B:     mb[0] = 8'h08;
					CH_F:     mb[0] = 8'h0C;
					CH_N:     mb[0] = CH_LF;
					CH_R:     mb[0] = CH_CR;
					CH_T:     mb[0] = CH_TAB;
					CH_U: begin
						mcnt = 3'd0; ph_n = PH_HEX1; dc_n = 2'd0; hv_n = '0;
					end
					default: begin
						mk[0] = K_ESC; ph_n = PH_WAIT;
					end
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hx[4]) begin
					mcnt = 3'd1; mk[0] = K_HEX; ph_n = PH_WAIT;
				end else begin
					hv_n = hv_new;
					dc_n = dcnt_q + 2'd1;
					if (dcnt_q == 2'd3) begin
						if (phase_q == PH_HEX1 && is_hi) begin
							hs_n = hv_new[9:0];
							ph_n = PH_BSL;
						end else if ((phase_q == PH_HEX1) ? is_lo : !is_lo) begin
							mcnt = 3'd1; mk[0] = K_SURR; ph_n = PH_WAIT;
						end else begin
							mcnt = u8.cnt; mb = u8.b; ph_n = PH_BODY;
						end
					end
				end
			end
			PH_BSL: begin
				if (data_s1 == CH_BSL) begin
					ph_n = PH_UCH;
				end else begin
					mcnt = 3'd1; mk[0] = K_SURR; ph_n = PH_WAIT;
				end
			end
			PH_UCH: begin
				if (data_s1 == CH_U) begin
					ph_n = PH_HEX2; dc_n = 2'd0; hv_n = '0;
				end else begin
					mcnt = 3'd1; mk[0] = K_SURR; ph_n = PH_WAIT;
				end
			end
			default: begin
				ph_n = PH_WAIT;
				if (data_s1 == CH_QUOTE) begin
					ph_n = PH_BODY;
				end else if (!ws || last_s1) begin
					mcnt = 3'd1; mk[0] = K_NOQUOTE;
				end
			end
		endcase

		bnd.cnt    = mcnt;
		bnd.byt    = {8'd0, mb};
		bnd.knd    = {K_DATA, mk};
		// buffer ran out inside a string: append the unterminated marker
		if (last_s1 && ph_n != PH_WAIT) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (3'(i) == mcnt) begin
					bnd.byt[i] = 8'd0;
					bnd.knd[i] = K_UNTERM;
				end
			end
			bnd.cnt = mcnt + 3'd1;
			ph_n    = PH_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			dcnt_q  <= '0;
			hval_q  <= '0;
			hsur_q  <= '0;
		end else if (step) begin
			phase_q <= ph_n;
			dcnt_q  <= dc_n;
			hval_q  <= hv_n;
			hsur_q  <= hs_n;
		end
	end

endmodule

### src/jsu_outq.sv
// ----------------------------------------------------------------------------
// JSON string unescape unit - result register
// Holds one result bundle and shifts it out one result per transaction.
// ----------------------------------------------------------------------------
module jsu_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::bundle_t bnd,
	output logic             can_load,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       out_byte,
	output logic [2:0]       kind,
	output logic             run_last
);
	import jsu_pkg::*;

	logic [2:0]              cnt_q;
	logic [MAX_RES-1:0][7:0] byt_q;
	logic [MAX_RES-1:0][2:0] knd_q;
	logic                    pop;

	assign res_valid = (cnt_q != 3'd0);
	assign pop       = res_valid && !res_stall;
	assign can_load  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && pop);
	assign out_byte  = byt_q[0];
	assign kind      = knd_q[0];
	assign run_last  = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bnd.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && bnd.cnt != 3'd0) begin
			byt_q <= bnd.byt;
			knd_q <= bnd.knd;
		end else if (pop) begin
			byt_q <= {8'd0, byt_q[MAX_RES-1:1]};
			knd_q <= {K_DATA, knd_q[MAX_RES-1:1]};
		end
	end

endmodule

### src/json_string_unescape_utf8_unit.sv
// ----------------------------------------------------------------------------
// JSON string unescape unit - top level
// Byte stream of JSON text in, unescaped UTF-8 bytes and status codes out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  byte    | byte_valid/byte_stall | data_byte, last_byte
//  res     | res_valid/res_stall   | out_byte, kind, run_last
//
// One byte per cycle while each byte gives at most one result and res_stall is low.
// A byte giving n results (UTF-8 sequence plus unterminated marker) holds the result
// register until all n are taken; input stalls behind it.
// Reset returns the parser to waiting for an opening quote, no results held.
// Bytes that give no result pass the decoder without using the result register.
module json_string_unescape_utf8_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       run_last
);
	import jsu_pkg::*;

	logic       vld_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       can_load;
	logic       step;
	logic       take;
	bundle_t    bnd;

	assign step       = vld_s1 && can_load;
	assign byte_stall = vld_s1 && !can_load;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.data_s1 (data_s1),
		.last_s1 (last_s1),
		.bnd     (bnd)
	);

	jsu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.bnd       (bnd),
		.can_load  (can_load),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.run_last  (run_last)
	);

endmodule

### src/jsu_checker.sv
// ----------------------------------------------------------------------------
// JSON string unescape unit - port checker
// Watches the top level ports for result ordering and payload rules.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [7:0] out_byte,
	input logic [2:0] kind,
	input logic       run_last
);
	import jsu_pkg::*;

	// a held result transaction stays offered
	`JSU_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	// status results carry a zero byte
	`JSU_ASSERT_NOW(a_status_zero, res_valid && kind != K_DATA, out_byte == 8'd0)
	// only data bytes can be followed by more results of the same input byte
	`JSU_ASSERT_NOW(a_nonlast_data, res_valid && !run_last, kind == K_DATA)
	// the rest of a run follows in the next cycle
	`JSU_ASSERT_NEXT(a_run_cont, res_valid && !res_stall && !run_last, res_valid)

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);

### tb/sv/tb_json_string_unescape_utf8_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON string unescape unit - testbench
// Feeds JSON text byte by byte: a short table of edge cases first, then
// random strings with escapes, surrogate pairs, faults and noise. Every
// result is compared with the table entry or an in-bench decoder under random
// input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_unit;
	import jsu_pkg::*;

	localparam int NUM_DIR     = 28;
	localparam int RAND_BYTES  = 320;
	localparam int IDLE_LIMIT  = 1000;
	localparam int SETTLE      = 16;
	localparam int SHOW_ERRORS = 10;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [7:0] ESC_SET [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E,
		8'h72, 8'h74};
	localparam logic [15:0] QUAD_EDGE [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
		16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

	typedef enum logic [3:0] {
		ST_WAIT, ST_BODY, ST_ESC, ST_HEX1, ST_BSL, ST_UCH, ST_HEX2
	} scan_st_e;

	typedef struct {
		logic [7:0] byt;
		logic [2:0] knd;
		logic       fin;
	} res_t;

	typedef struct {
		logic [7:0] d;
		logic       l;
	} stim_t;

	typedef struct {
		logic [7:0] d;
		logic       l;
		bit         typed;
		logic [7:0] eb;
		logic [2:0] ek;
	} dir_row_t;

	// typed rows carry their single result; the rest go through the decoder
	dir_row_t dir_tab [NUM_DIR] = '{
		'{8'h00, 1'b0, 1'b1, 8'h00, K_NOQUOTE},
		'{8'h20, 1'b1, 1'b1, 8'h00, K_NOQUOTE},
		'{8'h22, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'hFF, 1'b0, 1'b1, 8'hFF, K_DATA},
		'{8'h22, 1'b0, 1'b1, 8'h00, K_END},
		'{8'h22, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h1F, 1'b0, 1'b1, 8'h00, K_CTRL},
		'{8'h22, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h5C, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h75, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h64, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h38, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h30, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h30, 1'b0, 1'b0, 8'h00, K_DATA},
		// quote where the low surrogate should start: error, quote is dropped
		'{8'h22, 1'b0, 1'b1, 8'h00, K_SURR},
		'{8'h22, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h5C, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h75, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h44, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h42, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h46, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h46, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h5C, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h75, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h44, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h46, 1'b0, 1'b0, 8'h00, K_DATA},
		'{8'h46, 1'b0, 1'b0, 8'h00, K_DATA},
		// U+10FFFF then buffer end: four bytes plus unterminated
		'{8'h46, 1'b1, 1'b0, 8'h00, K_DATA}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic       run_last;

	json_string_unescape_utf8_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.kind       (kind),
		.run_last   (run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state
	scan_st_e    scan_st = ST_WAIT;
	logic [1:0]  nib_cnt = 2'd0;
	logic [15:0] quad = 16'h0000;
	logic [9:0]  hi_bits = 10'd0;
	res_t        byte_results[$];
	res_t        decoded_q[$];

	stim_t stim_q[$];
	int    strings_built = 0;
	int    bytes_taken = 0;
	int    results_seen = 0;
	int    mismatches = 0;
	int    kind_cnt [8];
	int    idle_cycles = 0;
	int    stall_mode = 0;
	int    stall_left = 0;
	bit    winding_down = 1'b0;

	function automatic int hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	function automatic void put(input logic [7:0] b, input logic [2:0] k);
		byte_results.insert(byte_results.size(), res_t'{b, k, 1'b0});
	endfunction

	function automatic void abort(input logic [2:0] k);
		put(8'h00, k);
		scan_st = ST_WAIT;
	endfunction

	function automatic void put_cp(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			put(cp[7:0], K_DATA);
		end else if (cp <= 21'h7FF) begin
			put({3'b110, cp[10:6]}, K_DATA);
			put({2'b10, cp[5:0]}, K_DATA);
		end else if (cp <= 21'hFFFF) begin
			put({4'b1110, cp[15:12]}, K_DATA);
			put({2'b10, cp[11:6]}, K_DATA);
			put({2'b10, cp[5:0]}, K_DATA);
		end else begin
			put({5'b11110, cp[20:18]}, K_DATA);
			put({2'b10, cp[17:12]}, K_DATA);
			put({2'b10, cp[11:6]}, K_DATA);
			put({2'b10, cp[5:0]}, K_DATA);
		end
	endfunction

	// shifts one hex digit into the quad; 1 once four digits are in
	function automatic bit take_nibble(input logic [7:0] c);
		int v;
		v = hex_val(c);
		if (v < 0) begin
			abort(K_HEX);
			return 1'b0;
		end
		quad = {quad[11:0], v[3:0]};
		if (nib_cnt == 2'd3) begin
			nib_cnt = 2'd0;
			return 1'b1;
		end
		nib_cnt = nib_cnt + 2'd1;
		return 1'b0;
	endfunction

	function automatic void decode_byte(input logic [7:0] c, input logic fin);
		bit ws;
		ws = (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A);
		byte_results.delete();
		case (scan_st)
			ST_BODY: begin
				if (c == CH_QUOTE) begin
					put(8'h00, K_END);
					scan_st = ST_WAIT;
				end else if (c < 8'h20) begin
					abort(K_CTRL);
				end else if (c == CH_BSL) begin
					scan_st = ST_ESC;
				end else begin
					put(c, K_DATA);
				end
			end
			ST_ESC: begin
				scan_st = ST_BODY;
				case (c)
					8'h22, 8'h5C, 8'h2F: put(c, K_DATA);
					8'h62: put(8'h08, K_DATA);
					8'h66: put(8'h0C, K_DATA);
					8'h6E: put(8'h0A, K_DATA);
					8'h72: put(8'h0D, K_DATA);
					8'h74: put(8'h09, K_DATA);
					CH_U: begin
						scan_st = ST_HEX1;
						nib_cnt = 2'd0;
						quad = 16'h0000;
					end
					default: abort(K_ESC);
				endcase
			end
			ST_HEX1: begin
				if (take_nibble(c)) begin
					if (quad >= 16'hD800 && quad <= 16'hDBFF) begin
						hi_bits = quad[9:0];
						scan_st = ST_BSL;
					end else if (quad >= 16'hDC00 && quad <= 16'hDFFF) begin
						abort(K_SURR);
					end else begin
						put_cp({5'd0, quad});
						scan_st = ST_BODY;
					end
				end
			end
			ST_BSL: begin
				if (c == CH_BSL) scan_st = ST_UCH;
				else abort(K_SURR);
			end
			ST_UCH: begin
				if (c == CH_U) begin
					scan_st = ST_HEX2;
					nib_cnt = 2'd0;
					quad = 16'h0000;
				end else begin
					abort(K_SURR);
				end
			end
			ST_HEX2: begin
				if (take_nibble(c)) begin
					if (quad < 16'hDC00 || quad > 16'hDFFF) begin
						abort(K_SURR);
					end else begin
						put_cp(21'h10000 + {1'b0, hi_bits, quad[9:0]});
						scan_st = ST_BODY;
					end
				end
			end
			default: begin
				scan_st = ST_WAIT;
				if (c == CH_QUOTE) scan_st = ST_BODY;
				else if (!ws || fin) put(8'h00, K_NOQUOTE);
			end
		endcase
		if (fin && scan_st != ST_WAIT) begin
			put(8'h00, K_UNTERM);
			scan_st = ST_WAIT;
		end
		if (byte_results.size() > 0) byte_results[byte_results.size() - 1].fin = 1'b1;
	endfunction

	// ---- stimulus generation ----

	function automatic void add_byte(input logic [7:0] d, input logic l);
		stim_q.insert(stim_q.size(), stim_t'{d, l});
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + {4'h0, n};
		return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
	endfunction

	function automatic void add_quad(input logic [15:0] v);
		add_byte(CH_BSL, 1'b0);
		add_byte(CH_U, 1'b0);
		for (int s = 12; s >= 0; s -= 4) add_byte(hex_char(v[s +: 4]), 1'b0);
	endfunction

	function automatic logic [7:0] ws_byte();
		case ($urandom_range(0, 3))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0D;
			default: return 8'h0A;
		endcase
	endfunction

	function automatic logic [15:0] pick_high();
		case ($urandom_range(0, 5))
			0: return 16'hD800;
			1: return 16'hDBFF;
			default: return 16'($urandom_range(16'hD800, 16'hDBFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_low();
		case ($urandom_range(0, 5))
			0: return 16'hDC00;
			1: return 16'hDFFF;
			default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
		endcase
	endfunction

	// one JSON string with random content, now and then broken or truncated
	function automatic void add_random_string();
		int          n_tok;
		int          sel;
		int          fault;
		int          open_idx;
		int          chop;
		logic [7:0]  b;
		logic [15:0] q;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3))
				add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end
		if ($urandom_range(0, 14) == 0) add_byte(ws_byte(), 1'b1);
		repeat ($urandom_range(0, 2)) add_byte(ws_byte(), 1'b0);
		add_byte(CH_QUOTE, 1'b0);
		open_idx = stim_q.size();
		n_tok = $urandom_range(0, 8);
		for (int t = 0; t < n_tok; t++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40) begin
				do b = 8'($urandom_range(8'h20, 8'hFF));
				while (b == CH_QUOTE || b == CH_BSL);
				add_byte(b, 1'b0);
			end else if (sel < 60) begin
				add_byte(CH_BSL, 1'b0);
				add_byte(ESC_SET[$urandom_range(0, 7)], 1'b0);
			end else if (sel < 85) begin
				case ($urandom_range(0, 3))
					0: add_quad(16'($urandom_range(0, 16'h7F)));
					1: add_quad(16'($urandom_range(16'h80, 16'h7FF)));
					2: add_quad(($urandom_range(0, 1) != 0) ?
						16'($urandom_range(16'h800, 16'hD7FF)) :
						16'($urandom_range(16'hE000, 16'hFFFF)));
					default: add_quad(QUAD_EDGE[$urandom_range(0, 7)]);
				endcase
			end else begin
				add_quad(pick_high());
				add_quad(pick_low());
			end
		end
		fault = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 7) : -1;
		case (fault)
			0: add_byte(8'($urandom_range(0, 8'h1F)), 1'b0);
			1: begin
				add_byte(CH_BSL, 1'b0);
				do b = 8'($urandom_range(0, 255));
				while (b inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72,
					8'h74, CH_U});
				add_byte(b, 1'b0);
			end
			2: begin
				// bad digit in a first quad or in the low half of a pair
				if ($urandom_range(0, 1) != 0) add_quad(pick_high());
				add_byte(CH_BSL, 1'b0);
				add_byte(CH_U, 1'b0);
				repeat ($urandom_range(0, 3))
					add_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
				do b = 8'($urandom_range(0, 255));
				while (hex_val(b) >= 0);
				add_byte(b, 1'b0);
			end
			3: add_quad(pick_low());
			4: begin
				add_quad(pick_high());
				do b = 8'($urandom_range(0, 255));
				while (b == CH_BSL);
				add_byte(b, 1'b0);
			end
			5: begin
				add_quad(pick_high());
				add_byte(CH_BSL, 1'b0);
				do b = 8'($urandom_range(0, 255));
				while (b == CH_U);
				add_byte(b, 1'b0);
			end
			6: begin
				add_quad(pick_high());
				do q = 16'($urandom_range(0, 16'hFFFF));
				while (q >= 16'hDC00 && q <= 16'hDFFF);
				add_quad(q);
			end
			7: begin
				// buffer ends inside the string, possibly mid-escape
				chop = $urandom_range(0, 3);
				while (chop > 0 && stim_q.size() > open_idx) begin
					void'(stim_q.pop_back());
					chop--;
				end
				stim_q[stim_q.size() - 1].l = 1'b1;
			end
			default: add_byte(CH_QUOTE, $urandom_range(0, 4) == 0);
		endcase
		strings_built++;
	endfunction

	function automatic void note_bad(input string msg);
		mismatches++;
		if (mismatches <= SHOW_ERRORS) $display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// ---- monitor: expectations on input transactions, checks on results ----
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				decode_byte(data_byte, last_byte);
				if (bytes_taken < NUM_DIR && dir_tab[bytes_taken].typed)
					decoded_q.insert(decoded_q.size(), res_t'{dir_tab[bytes_taken].eb,
						dir_tab[bytes_taken].ek, 1'b1});
				else
					foreach (byte_results[j])
						decoded_q.insert(decoded_q.size(), byte_results[j]);
				bytes_taken++;
			end
			if (res_valid && !res_stall) begin
				if (decoded_q.size() == 0) begin
					note_bad($sformatf("unexpected result: byte %02h kind %0d last %0b",
						out_byte, kind, run_last));
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.byt || kind !== want.knd || run_last !== want.fin)
						note_bad($sformatf({"result %0d: exp byte %02h kind %0d last %0b, ",
							"got byte %02h kind %0d last %0b"}, results_seen, want.byt,
							want.knd, want.fin, out_byte, kind, run_last));
				end
				results_seen++;
				kind_cnt[kind]++;
			end
			// receiver: free runs, random stalls and solid stall stretches
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(10, 60);
			end
			stall_left--;
			if (winding_down || stall_mode == 0) res_stall <= 1'b0;
			else if (stall_mode == 3) res_stall <= 1'b1;
			else res_stall <= ($urandom_range(0, 99) < ((stall_mode == 1) ? 50 : 20));
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ---- sender ----
	initial begin
		int i;
		int burst;
		int drain_at;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		foreach (kind_cnt[k]) kind_cnt[k] = 0;

		for (int k = 0; k < NUM_DIR; k++) add_byte(dir_tab[k].d, dir_tab[k].l);
		while (stim_q.size() < NUM_DIR + RAND_BYTES) add_random_string();
		drain_at = NUM_DIR + RAND_BYTES / 2;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		i = 0;
		burst = 0;
		while (i < stim_q.size()) begin
			if (i == NUM_DIR || i == drain_at) begin
				// hold off until every pending result is out
				byte_valid <= 1'b0;
				@(posedge clk);
				while (decoded_q.size() != 0) @(posedge clk);
				burst = $urandom_range(1, 10);
			end else if (burst == 0) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 12);
			end
			byte_valid <= 1'b1;
			data_byte <= stim_q[i].d;
			last_byte <= stim_q[i].l;
			@(posedge clk);
			while (byte_stall) @(posedge clk);
			burst--;
			i++;
		end
		byte_valid <= 1'b0;
		winding_down = 1'b1;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d bytes (%0d from the edge-case table, %0d random strings),",
			bytes_taken, NUM_DIR, strings_built);
		$display("%0d results checked; kinds seen: data %0d end %0d ctrl %0d esc %0d",
			results_seen, kind_cnt[K_DATA], kind_cnt[K_END], kind_cnt[K_CTRL],
			kind_cnt[K_ESC]);
		$display("  hex %0d surr %0d unterm %0d noquote %0d",
			kind_cnt[K_HEX], kind_cnt[K_SURR], kind_cnt[K_UNTERM], kind_cnt[K_NOQUOTE]);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
